[rtl/psr_pkg.sv]
// ----------------------------------------------------------------------------
// psr_pkg: shared types and constants of the power series reciprocal unit
// Field widths, stream word layout, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package psr_pkg;

   // parameter defaults
   localparam int DEF_MAX_TERMS = 32;
   localparam int DEF_FRAC_BITS = 16;

   // field widths
   localparam int COEFF_W = 32;
   localparam int TERM_W  = 32;
   localparam int TIDX_W  = 5;
   localparam int STAT_W  = 2;

   // stream word widths, data words padded to whole bytes
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_FULL = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   // saturation limits of a 32-bit signed term
   localparam logic signed [TERM_W-1:0] TERM_MAX = 32'sh7fff_ffff;
   localparam logic signed [TERM_W-1:0] TERM_MIN = 32'sh8000_0000;

endpackage

[rtl/psr_store.sv]
// ----------------------------------------------------------------------------
// psr_store: term store
// Synchronous memory, one write and one read port, read data registered.
// ----------------------------------------------------------------------------
module psr_store #(
   parameter int DEPTH = psr_pkg::DEF_MAX_TERMS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [psr_pkg::TERM_W-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [psr_pkg::TERM_W-1:0]    rd_data
);
   import psr_pkg::*;

   logic [TERM_W-1:0] mem [DEPTH];
   logic [TERM_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/psr_div.sv]
// ----------------------------------------------------------------------------
// psr_div: reciprocal divider
// Restoring divider, one quotient bit a cycle, for 2^(2*FRAC_BITS) / divisor
// with an unsigned divisor magnitude.
// ----------------------------------------------------------------------------
module psr_div #(
   parameter int FRAC_BITS = psr_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [psr_pkg::COEFF_W-1:0]    divisor,
   output logic                           done,
   output logic [2*FRAC_BITS:0]           quotient
);
   import psr_pkg::*;

   localparam int QW = 2 * FRAC_BITS + 1;
   localparam int CW = $clog2(QW);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [COEFF_W-1:0] rem_ff, rem_in;
   logic [COEFF_W-1:0] dvs_ff, dvs_in;
   logic [QW-1:0]      quo_ff, quo_in;

   logic               dividend_bit;
   logic [COEFF_W:0]   shifted;
   logic [COEFF_W:0]   trial;

   // one restoring step; the dividend has only its top bit set
   always_comb begin
      dividend_bit = (cnt_ff == CW'(QW - 1));
      shifted      = {rem_ff, dividend_bit};
      trial        = shifted - {1'b0, dvs_ff};
      busy_in      = busy_ff;
      done_in      = 1'b0;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (!trial[COEFF_W]) begin
            rem_in = trial[COEFF_W-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[COEFF_W-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/power_series_reciprocal_unit.sv]
// ----------------------------------------------------------------------------
// power_series_reciprocal_unit: streaming power series inversion
// Takes coefficients a_i and returns b_i of the series b with a*b = 1, in
// signed fixed point, keeping a and b terms in two term memories.
//
//   channel   dir   word                                   handshake
//   req_      in    tdata: coeff, tuser: start_req         tvalid/tready
//   rsp_      out   tdata: term, term_index, status        tvalid/tready
//
// Term 0 comes from the restoring divider (Q16.16 by default); term i runs
// one multiply-accumulate a cycle over the two term memories, then read,
// multiply, saturate and scaling steps; failed or overflowing items go
// straight to the output register. One item is in work at a time.
// Reset clears the term index, the failure flag, 1/a_0 and the handshakes.
// A stalled result waits in the output register; the next word is taken
// meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module power_series_reciprocal_unit #(
   parameter int MAX_TERMS = psr_pkg::DEF_MAX_TERMS,
   parameter int FRAC_BITS = psr_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psr_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [31:0] coeff
   input  logic [psr_pkg::REQ_TUSER_W-1:0]   req_tuser,   // [0] start_req
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psr_pkg::RSP_TDATA_W-1:0]   rsp_tdata    // [31:0] term,
                                                          // [36:32] term_index,
                                                          // [38:37] status,
                                                          // [39] zero
);
   import psr_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TERMS);
   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int QW     = 2 * FRAC_BITS + 1;
   localparam int PROD_W = 2 * TERM_W;
   localparam int PSH_W  = PROD_W - FRAC_BITS;
   localparam int ACC_W  = PSH_W + IDX_W;
   localparam int NEG_W  = PROD_W + 1;
   localparam int NSH_W  = NEG_W - FRAC_BITS;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DIV    = 7'b0000010,
      S_MAC    = 7'b0000100,
      S_SUMSAT = 7'b0001000,
      S_MUL    = 7'b0010000,
      S_ROUND  = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   // control registers
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      next_index_ff, next_index_in;
   logic                  failed_ff, failed_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  prod_vld_ff, prod_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [TERM_W-1:0] recip_ff, recip_in;

   // payload registers
   logic [IDX_W-1:0]         cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic                     a_neg_ff, a_neg_in;
   logic                     store_ff, store_in;
   logic                     sat_ff, sat_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [TERM_W-1:0] sum_sat_ff, sum_sat_in;
   logic signed [TERM_W-1:0] res_term_ff, res_term_in;
   logic [TIDX_W-1:0]        res_idx_ff, res_idx_in;
   status_type               res_status_ff, res_status_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // item fields
   logic signed [COEFF_W-1:0] coeff;
   logic                      start_req;
   logic                      accept;
   logic [CNT_W-1:0]          idx_eff;
   logic                      failed_eff;
   logic [CNT_W+TIDX_W-1:0]   idx_wide;
   logic [COEFF_W-1:0]        coeff_mag;

   // memory and divider connections
   logic                   a_we;
   logic [IDX_W-1:0]       a_waddr;
   logic [TERM_W-1:0]      a_rdata;
   logic                   b_we;
   logic [TERM_W-1:0]      b_rdata;
   logic                   div_start;
   logic                   div_done;
   logic [QW-1:0]          div_quo;

   // arithmetic
   logic [PROD_W-1:0]        quo_ext;
   logic signed [TERM_W-1:0] recip_val;
   logic                     recip_ovf;
   logic signed [TERM_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [ACC_W-1:0]  prod_ext;
   logic                     acc_ovf;
   logic signed [NEG_W-1:0]  neg_prod;
   logic signed [NEG_W-1:0]  neg_sh;
   logic                     term_ovf;
   logic                     out_free;

   assign coeff      = req_tdata[COEFF_W-1:0];
   assign start_req  = req_tuser[0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign idx_eff    = start_req ? '0 : next_index_ff;
   assign failed_eff = start_req ? 1'b0 : failed_ff;
   assign idx_wide   = (CNT_W + TIDX_W)'(idx_eff);
   assign coeff_mag  = coeff[COEFF_W-1] ? (~coeff + 1'b1) : coeff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // term memories
   psr_store #(.DEPTH(MAX_TERMS)) u_a_store (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (coeff),
      .rd_addr (k_ff),
      .rd_data (a_rdata)
   );

   psr_store #(.DEPTH(MAX_TERMS)) u_b_store (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (cur_idx_ff),
      .wr_data (res_term_ff),
      .rd_addr (cur_idx_ff - k_ff),
      .rd_data (b_rdata)
   );

   // divider for 1/a_0
   psr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (coeff_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   // signed, saturated reciprocal
   always_comb begin
      quo_ext   = {{(PROD_W-QW){1'b0}}, div_quo};
      recip_ovf = 1'b0;
      if (a_neg_ff) begin
         if (quo_ext > PROD_W'(64'h8000_0000)) begin
            recip_ovf = 1'b1;
            recip_val = TERM_MIN;
         end else begin
            recip_val = ~quo_ext[TERM_W-1:0] + 1'b1;
         end
      end else begin
         if (quo_ext > PROD_W'(64'h7fff_ffff)) begin
            recip_ovf = 1'b1;
            recip_val = TERM_MAX;
         end else begin
            recip_val = quo_ext[TERM_W-1:0];
         end
      end
   end

   // shared multiplier operands and product scaling
   always_comb begin
      mul_a    = (state_ff == S_MUL) ? recip_ff   : a_rdata;
      mul_b    = (state_ff == S_MUL) ? sum_sat_ff : b_rdata;
      prod_in  = mul_a * mul_b;
      prod_sh  = prod_ff >>> FRAC_BITS;
      prod_ext = {{(ACC_W-PSH_W){prod_sh[PSH_W-1]}}, prod_sh[PSH_W-1:0]};
      acc_ovf  = !((&acc_ff[ACC_W-1:TERM_W-1]) || !(|acc_ff[ACC_W-1:TERM_W-1]));
      neg_prod = -{prod_ff[PROD_W-1], prod_ff};
      neg_sh   = neg_prod >>> FRAC_BITS;
      term_ovf = !((&neg_sh[NSH_W-1:TERM_W-1]) || !(|neg_sh[NSH_W-1:TERM_W-1]));
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      next_index_in = next_index_ff;
      failed_in     = failed_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = 1'b0;
      prod_vld_in   = 1'b0;
      recip_in      = recip_ff;
      cur_idx_in    = cur_idx_ff;
      k_in          = k_ff;
      a_neg_in      = a_neg_ff;
      store_in      = store_ff;
      sat_in        = sat_ff;
      acc_in        = acc_ff;
      sum_sat_in    = sum_sat_ff;
      res_term_in   = res_term_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      a_we          = 1'b0;
      a_waddr       = idx_eff[IDX_W-1:0];
      b_we          = 1'b0;
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_idx_in    = idx_wide[TIDX_W-1:0];
               res_term_in   = '0;
               res_status_in = ST_OK;
               sat_in        = 1'b0;
               store_in      = 1'b0;
               failed_in     = failed_eff;
               cur_idx_in    = idx_eff[IDX_W-1:0];
               state_in      = S_EMIT;
               if (idx_eff != CNT_W'(MAX_TERMS)) begin
                  next_index_in = idx_eff + 1'b1;
               end else begin
                  next_index_in = idx_eff;
               end
               if (failed_eff) begin
                  res_status_in = ST_ZERO;
               end else if (idx_eff == CNT_W'(MAX_TERMS)) begin
                  res_status_in = ST_FULL;
               end else if (idx_eff == '0) begin
                  if (coeff == '0) begin
                     failed_in     = 1'b1;
                     res_status_in = ST_ZERO;
                  end else begin
                     a_we      = 1'b1;
                     div_start = 1'b1;
                     a_neg_in  = coeff[COEFF_W-1];
                     store_in  = 1'b1;
                     state_in  = S_DIV;
                  end
               end else begin
                  a_we          = 1'b1;
                  store_in      = 1'b1;
                  k_in          = IDX_W'(1);
                  issue_done_in = 1'b0;
                  acc_in        = '0;
                  state_in      = S_MAC;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               recip_in    = recip_val;
               res_term_in = recip_val;
               sat_in      = recip_ovf;
               state_in    = S_EMIT;
            end
         end
         S_MAC: begin
            // issue one read pair a cycle, then drain the pipeline
            if (!issue_done_ff) begin
               rd_vld_in = 1'b1;
               if (k_ff == cur_idx_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            prod_vld_in = rd_vld_ff;
            if (prod_vld_ff) begin
               acc_in = acc_ff + prod_ext;
            end
            if (issue_done_ff && !rd_vld_ff && !prod_vld_ff) begin
               state_in = S_SUMSAT;
            end
         end
         S_SUMSAT: begin
            if (acc_ovf) begin
               sum_sat_in = acc_ff[ACC_W-1] ? TERM_MIN : TERM_MAX;
               sat_in     = 1'b1;
            end else begin
               sum_sat_in = acc_ff[TERM_W-1:0];
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (term_ovf) begin
               res_term_in = neg_sh[NEG_W-1] ? TERM_MIN : TERM_MAX;
               sat_in      = 1'b1;
            end else begin
               res_term_in = neg_sh[TERM_W-1:0];
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               ((res_status_ff == ST_OK) && sat_ff) ? ST_SAT
                                                                    : res_status_ff,
                               res_idx_ff, res_term_ff};
               b_we         = store_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_index_ff <= '0;
         failed_ff     <= 1'b0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         recip_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         next_index_ff <= next_index_in;
         failed_ff     <= failed_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         prod_vld_ff   <= prod_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         recip_ff      <= recip_in;
      end
   end

   // datapath state
   always_ff @(posedge clock) begin
      cur_idx_ff    <= cur_idx_in;
      k_ff          <= k_in;
      a_neg_ff      <= a_neg_in;
      store_ff      <= store_in;
      sat_ff        <= sat_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      sum_sat_ff    <= sum_sat_in;
      res_term_ff   <= res_term_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // failed and overflowing items never carry a nonzero term
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[38:37] == ST_ZERO || rsp_tdata[38:37] == ST_FULL)
      |-> rsp_tdata[31:0] == '0)
      else $error("failed item carries a nonzero term");

   // memory reads in flight only while accumulating
   assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff || prod_vld_ff) |-> state_ff == S_MAC)
      else $error("accumulate pipeline active outside accumulation");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider result outside reciprocal step");

   // an accepted item leaves the sequencer busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second item taken while one is in work");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: power series reciprocal unit
// Streams coefficient series into the unit and checks every returned term,
// index and status against a fixed-point inversion predictor kept in step
// with each accepted word. Covers the first-term divide, zero a_0, capacity
// overflow, saturation, and random series under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import psr_pkg::*;

   localparam int TERM_SLOTS  = DEF_MAX_TERMS;
   localparam int FRAC        = DEF_FRAC_BITS;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 48;
   localparam int IDLE_PCT    = 36;

   typedef struct packed {
      logic signed [TERM_W-1:0] term;
      logic [TIDX_W-1:0]        index;
      status_type               status;
   } term_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   // predictor state
   logic signed [COEFF_W-1:0] coeff_store [TERM_SLOTS];
   logic signed [TERM_W-1:0]  inverse_store [TERM_SLOTS];
   logic signed [TERM_W-1:0]  recip_a0;
   int unsigned               next_idx;
   bit                        series_dead;

   term_result_type pending_terms [$];
   term_result_type oldest;
   int              errors = 0;
   int              mismatches = 0;
   int              idle_cycles = 0;
   bit              steady = 1'b0;

   power_series_reciprocal_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // saturate to a 32-bit signed term
   function automatic logic signed [TERM_W-1:0] clamp_term(input longint v, inout bit hit);
      if (v > longint'(TERM_MAX)) begin
         hit = 1'b1;
         return TERM_MAX;
      end
      if (v < longint'(TERM_MIN)) begin
         hit = 1'b1;
         return TERM_MIN;
      end
      return v[TERM_W-1:0];
   endfunction

   // next reciprocal coefficient for one accepted word
   function automatic term_result_type invert_next(input logic signed [COEFF_W-1:0] coeff,
                                                   input bit start);
      term_result_type r;
      longint          acc;
      bit              hit;
      int unsigned     idx;
      r.term   = '0;
      r.status = ST_OK;
      hit      = 1'b0;
      if (start) begin
         next_idx    = 0;
         series_dead = 1'b0;
      end
      idx = next_idx;
      if (series_dead) begin
         r.status = ST_ZERO;
      end else if (idx >= TERM_SLOTS) begin
         r.status = ST_FULL;
      end else if (idx == 0) begin
         if (coeff == 0) begin
            series_dead = 1'b1;
            r.status    = ST_ZERO;
         end else begin
            recip_a0 = clamp_term((64'sd1 <<< (2 * FRAC)) / longint'(coeff), hit);
            coeff_store[0]   = coeff;
            inverse_store[0] = recip_a0;
            r.term           = recip_a0;
         end
      end else begin
         coeff_store[idx] = coeff;
         acc = 0;
         for (int k = 1; k <= idx; k++)
            acc += (longint'(coeff_store[k]) * longint'(inverse_store[idx - k])) >>> FRAC;
         acc    = clamp_term(acc, hit);
         r.term = clamp_term((-longint'(recip_a0) * acc) >>> FRAC, hit);
         inverse_store[idx] = r.term;
      end
      if (r.status == ST_OK && hit)
         r.status = ST_SAT;
      if (next_idx < TERM_SLOTS)
         next_idx++;
      r.index = idx[TIDX_W-1:0];
      return r;
   endfunction

   // send one word, with random idle cycles ahead of it
   task automatic send_coeff(input logic signed [COEFF_W-1:0] coeff, input bit start);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= coeff;
      req_tuser  <= start;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      pending_terms.insert(pending_terms.size(), invert_next(coeff, start));
   endtask

   // random coefficient, shaped by position in the series
   function automatic logic signed [COEFF_W-1:0] pick_coeff(input bit lead);
      int unsigned mode;
      logic signed [COEFF_W-1:0] mag;
      mode = $urandom_range(99);
      if (mode < 60) begin
         mag = lead ? $urandom_range(262144, 16384) : $urandom_range(98304, 0);
         return $urandom_range(1) ? -mag : mag;
      end else if (mode < 80) begin
         mag = $urandom_range(16384, 0);
         return $urandom_range(1) ? -mag : mag;
      end else if (mode < 95) begin
         return $urandom;
      end
      case ($urandom_range(4))
         0: return TERM_MAX;
         1: return TERM_MIN;
         2: return 0;
         3: return 1;
         default: return -1;
      endcase
   endfunction

   // one series: mostly short, sometimes past capacity, with some noise words
   task automatic send_series();
      int unsigned len;
      len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(36, 13);
      for (int j = 0; j < len; j++) begin
         if (j > 0 && $urandom_range(99) < 6)
            send_coeff($urandom, 1'($urandom_range(1)));
         else
            send_coeff(pick_coeff(j == 0), j == 0);
      end
   endtask

   // first term, zero a_0, divide extremes and saturation
   task automatic test_directed();
      send_coeff(32'sh0001_0000, 1'b0);   // no start after reset still gives a_0
      send_coeff(32'sh0000_8000, 1'b0);
      send_coeff(32'sh0000_0000, 1'b1);   // zero a_0 fails the series
      send_coeff(32'sh0001_0000, 1'b0);
      send_coeff(32'sh0000_0001, 1'b1);   // 1/a_0 overflows high
      send_coeff(TERM_MAX, 1'b0);         // sum overflows
      send_coeff(32'shffff_ffff, 1'b1);   // 1/a_0 overflows low
      send_coeff(TERM_MIN, 1'b0);
      send_coeff(TERM_MAX, 1'b1);
      send_coeff(TERM_MIN, 1'b0);
      send_coeff(TERM_MIN, 1'b1);
      send_coeff(TERM_MAX, 1'b0);
      send_coeff(TERM_MIN, 1'b0);
      send_coeff(32'sh0002_0000, 1'b1);
      send_coeff(32'shffff_0000, 1'b0);
      send_coeff(32'sh0000_0001, 1'b0);
      send_coeff(32'shffff_8000, 1'b1);
      send_coeff(32'shffff_ffff, 1'b0);
      send_coeff(32'sh0001_0000, 1'b1);
   endtask

   // series running past capacity, healthy and failed
   task automatic test_capacity();
      send_coeff(pick_coeff(1'b1), 1'b1);
      for (int j = 1; j < TERM_SLOTS + 3; j++)
         send_coeff(pick_coeff(1'b0), 1'b0);
      send_coeff(0, 1'b1);
      for (int j = 1; j < TERM_SLOTS + 3; j++)
         send_coeff($urandom, 1'b0);
   endtask

   // random series under random stalls
   task automatic test_random_series();
      for (int n = 0; n < 50; n++)
         send_series();
   endtask

   // random series with no idle cycles on either side
   task automatic test_back_to_back();
      steady = 1'b1;
      for (int n = 0; n < 15; n++)
         send_series();
      steady = 1'b0;
   endtask

   // result side ready, idling at random
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_terms.size() == 0) begin
            errors++;
            if (mismatches < 10)
               $display("unexpected result word %h", rsp_tdata);
            mismatches++;
         end else begin
            oldest = pending_terms.pop_front();
            if (rsp_tdata[31:0] !== oldest.term || rsp_tdata[36:32] !== oldest.index ||
                rsp_tdata[38:37] !== oldest.status || rsp_tdata[39] !== 1'b0) begin
               errors++;
               if (mismatches < 10)
                  $display("mismatch: expected term %h index %0d status %0d, got word %h",
                           oldest.term, oldest.index, oldest.status, rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      next_idx    = 0;
      series_dead = 1'b0;
      recip_a0    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity();
      test_random_series();
      test_back_to_back();
      test_random_series();

      req_tvalid <= 1'b0;
      while (pending_terms.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_terms.size() != 0)
         errors++;
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
